// ===== hw/rtl/dkms_pkg.sv =====
package dkms_pkg;

    // Fixed field widths of the item and result channels.
    localparam int ROW_W     = 8;
    localparam int ROW_IDX_W = 3;
    localparam int COL_W     = 5;

    // Configuration register widths and the write data width.
    localparam int DEMUX_BITS_W = 3;
    localparam int DIRECT_CNT_W = 4;
    localparam int ROWS_USE_W   = 4;
    localparam int CFG_DATA_W   = 4;
    localparam int CFG_INDEX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_DEMUX_SELECT_BITS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIRECT_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE         = 2'd2;

    // Configuration reset values.
    localparam logic [DEMUX_BITS_W-1:0] DEMUX_BITS_RESET = 3'd4;
    localparam logic [DIRECT_CNT_W-1:0] DIRECT_CNT_RESET = 4'd8;
    localparam logic [ROWS_USE_W-1:0]   ROWS_USE_RESET   = 4'd8;

    // Matrix limits. The row limit never exceeds the width of the row field.
    localparam int MAX_ROWS               = 8;
    localparam int MAX_DEMUX_BITS_DEF     = 4;
    localparam int MAX_DIRECT_COLUMNS_DEF = 8;
    localparam int ROW_LIMIT = (MAX_ROWS < ROW_W) ? MAX_ROWS : ROW_W;

    // Depth of the queue between the classifying front and the event back end.
    localparam int ITEM_QUEUE_DEPTH = 4;
    localparam int QPTR_W           = $clog2(ITEM_QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(ITEM_QUEUE_DEPTH + 1);

    // One classified column: which keys changed and what the back end reports.
    typedef struct packed {
        logic [ROW_W-1:0] changed;
        logic [ROW_W-1:0] sample;
        logic [COL_W-1:0] column;
        logic             pass_done;
        logic             any_down;
        logic [COL_W-1:0] next_column;
    } dkms_item_t;

endpackage

// ===== hw/rtl/dkms_front.sv =====
module dkms_front
    import dkms_pkg::*;
#(
    parameter int MAX_DEMUX_BITS     = MAX_DEMUX_BITS_DEF,
    parameter int MAX_DIRECT_COLUMNS = MAX_DIRECT_COLUMNS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [ROW_W-1:0]       row_bits,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [QCNT_W-1:0]      q_count,
    output logic                   q_push,
    output dkms_item_t             q_item
);

    localparam int DEPTH = (1 << MAX_DEMUX_BITS) + MAX_DIRECT_COLUMNS;
    localparam int CW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    // Configuration registers.
    logic [DEMUX_BITS_W-1:0] demux_bits_reg;
    logic [DIRECT_CNT_W-1:0] direct_cnt_reg;
    logic [ROWS_USE_W-1:0]   rows_use_reg;
    logic                    cfg_hit;

    // Column sequencer and pass state.
    logic [CW-1:0]    pos_reg, pos_next;
    logic [ROW_W-1:0] parked_reg;
    logic             pass_any_reg;

    // Read stage.
    logic             s1_valid_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [ROW_W-1:0] s1_rows_reg;
    logic             s1_done_reg;
    logic [COL_W-1:0] s1_next_reg;
    logic [ROW_W-1:0] rd_data_reg;

    // Key state memory with one valid bit per column.
    logic [ROW_W-1:0] key_mem [DEPTH];
    logic [DEPTH-1:0] key_valid_reg;

    logic [DEMUX_BITS_W-1:0] eff_bits;
    logic [NW-1:0]           demux_cols;
    logic [NW-1:0]           eff_direct;
    logic [NW-1:0]           total;
    logic [ROWS_USE_W-1:0]   eff_rows;
    logic [ROW_W-1:0]        mask;
    logic                    accept;
    logic [CW-1:0]           col_cur;
    logic [NW-1:0]           col_inc;
    logic                    col_done;
    logic [CW+COL_W-1:0]     next_wide;
    logic [CW+COL_W-1:0]     s1_col_wide;
    logic [ROW_W-1:0]        old_state;
    logic [ROW_W-1:0]        held;
    logic                    s1_is_demux;
    logic                    s1_is_parked;
    logic [ROW_W-1:0]        sample;
    logic [ROW_W-1:0]        new_state;
    logic                    any_now;

    assign cfg_ready = 1'b1;

    // Effective register values, saturated into their ranges.
    always_comb
    begin
        eff_bits = demux_bits_reg;
        if (eff_bits == '0)
        begin
            eff_bits = DEMUX_BITS_W'(1);
        end
        if (eff_bits > DEMUX_BITS_W'(MAX_DEMUX_BITS))
        begin
            eff_bits = DEMUX_BITS_W'(MAX_DEMUX_BITS);
        end
        demux_cols = NW'(1) << eff_bits;

        if ({1'b0, direct_cnt_reg} > 5'(MAX_DIRECT_COLUMNS))
        begin
            eff_direct = NW'(MAX_DIRECT_COLUMNS);
        end
        else
        begin
            eff_direct = NW'(direct_cnt_reg);
        end
        total = demux_cols + eff_direct;

        eff_rows = rows_use_reg;
        if (eff_rows == '0)
        begin
            eff_rows = ROWS_USE_W'(1);
        end
        if (eff_rows > ROWS_USE_W'(ROW_LIMIT))
        begin
            eff_rows = ROWS_USE_W'(ROW_LIMIT);
        end
        for (int i = 0; i < ROW_W; i++)
        begin
            mask[i] = (ROWS_USE_W'(i) < eff_rows);
        end
    end

    // Room is reserved for the item in the read stage as well.
    assign full   = ({1'b0, q_count} + (QCNT_W+1)'(s1_valid_reg))
                    >= (QCNT_W+1)'(ITEM_QUEUE_DEPTH);
    assign accept = push && !full;

    // Column to sample now and the one to announce after it.
    always_comb
    begin
        col_cur   = (NW'(pos_reg) >= total) ? '0 : pos_reg;
        col_inc   = NW'(col_cur) + NW'(1);
        col_done  = (col_inc >= total);
        pos_next  = col_done ? '0 : CW'(col_inc);
        next_wide = {{COL_W{1'b0}}, pos_next};
    end

    // Configuration decode; a write to a listed register restarts the pass.
    always_comb
    begin
        case (cfg_index)
            REG_DEMUX_SELECT_BITS:   cfg_hit = cfg_valid;
            REG_DIRECT_COLUMN_COUNT: cfg_hit = cfg_valid;
            REG_ROWS_IN_USE:         cfg_hit = cfg_valid;
            default:                 cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            demux_bits_reg <= DEMUX_BITS_RESET;
            direct_cnt_reg <= DIRECT_CNT_RESET;
            rows_use_reg   <= ROWS_USE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DEMUX_SELECT_BITS:   demux_bits_reg <= cfg_data[DEMUX_BITS_W-1:0];
                REG_DIRECT_COLUMN_COUNT: direct_cnt_reg <= cfg_data[DIRECT_CNT_W-1:0];
                REG_ROWS_IN_USE:         rows_use_reg   <= cfg_data[ROWS_USE_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Classify the column held in the read stage.
    always_comb
    begin
        s1_col_wide  = {{COL_W{1'b0}}, s1_col_reg};
        old_state    = key_valid_reg[s1_col_reg] ? rd_data_reg : '0;
        held         = parked_reg & mask;
        s1_is_demux  = (NW'(s1_col_reg) < demux_cols);
        s1_is_parked = (NW'(s1_col_reg) == (demux_cols - NW'(1)));
        if (s1_is_demux)
        begin
            sample = s1_rows_reg;
        end
        else
        begin
            sample = ((s1_rows_reg & ~held) | (old_state & held)) & mask;
        end
        new_state = (old_state & ~mask) | sample;
        any_now   = pass_any_reg || (sample != '0);

        q_push              = s1_valid_reg;
        q_item.changed      = (sample ^ old_state) & mask;
        q_item.sample       = sample;
        q_item.column       = s1_col_wide[COL_W-1:0];
        q_item.pass_done    = s1_done_reg;
        q_item.any_down     = s1_done_reg && any_now;
        q_item.next_column  = s1_next_reg;
    end

    // Control state of the sequencer and the read stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            parked_reg    <= '0;
            pass_any_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            key_valid_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (cfg_hit)
            begin
                pos_reg <= '0;
            end
            else if (accept)
            begin
                pos_reg <= pos_next;
            end

            if (cfg_hit)
            begin
                pass_any_reg <= 1'b0;
            end
            else if (s1_valid_reg)
            begin
                pass_any_reg <= s1_done_reg ? 1'b0 : any_now;
            end

            if (s1_valid_reg && s1_is_parked)
            begin
                parked_reg <= s1_rows_reg;
            end
            if (s1_valid_reg)
            begin
                key_valid_reg[s1_col_reg] <= 1'b1;
            end
        end
    end

    // Read stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg  <= col_cur;
            s1_rows_reg <= row_bits & mask;
            s1_done_reg <= col_done;
            s1_next_reg <= next_wide[COL_W-1:0];
        end
    end

    // Key state memory: read on accept, written back from the read stage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= key_mem[col_cur];
        end
        if (s1_valid_reg)
        begin
            key_mem[s1_col_reg] <= new_state;
        end
    end

endmodule

// ===== hw/rtl/dkms_queue.sv =====
module dkms_queue
    import dkms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  dkms_item_t        wr_item,
    input  logic              rd_en,
    output dkms_item_t        rd_item,
    output logic              q_empty,
    output logic [QCNT_W-1:0] count
);

    dkms_item_t          entry_reg [ITEM_QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign rd_item = entry_reg[rd_ptr_reg];
    assign q_empty = (count_reg == '0);
    assign count   = count_reg;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(ITEM_QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + QPTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(ITEM_QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + QPTR_W'(1);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== hw/rtl/dkms_back.sv =====
module dkms_back
    import dkms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dkms_item_t           head,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic                 event_valid,
    output logic [ROW_IDX_W-1:0] event_row,
    output logic [COL_W-1:0]     event_column,
    output logic                 event_pressed,
    output logic                 last_of_item,
    output logic                 pass_done,
    output logic                 any_key_down,
    output logic [COL_W-1:0]     next_column
);

    logic                 out_valid_reg;
    logic                 started_reg;
    logic [ROW_W-1:0]     remain_reg;
    logic                 ev_valid_reg;
    logic [ROW_IDX_W-1:0] ev_row_reg;
    logic [COL_W-1:0]     ev_col_reg;
    logic                 ev_pressed_reg;
    logic                 last_reg;
    logic                 done_reg;
    logic                 any_reg;
    logic [COL_W-1:0]     next_col_reg;

    logic [ROW_W-1:0]     remain;
    logic [ROW_IDX_W-1:0] sel;
    logic [ROW_W-1:0]     remain_after;
    logic                 has_event;
    logic                 is_last;
    logic                 load;

    // Pick the lowest changed row still to be reported for the head item.
    always_comb
    begin
        remain = started_reg ? remain_reg : head.changed;
        sel    = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (remain[i])
            begin
                sel = ROW_IDX_W'(i);
            end
        end
        remain_after = remain & ~(ROW_W'(1) << sel);
        has_event    = (remain != '0);
        is_last      = (remain_after == '0);
    end

    assign empty = !out_valid_reg;
    assign load  = !q_empty && (!out_valid_reg || pop);
    assign q_pop = load && is_last;

    // Output register control and per-item progress.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                started_reg   <= !is_last;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            remain_reg     <= remain_after;
            ev_valid_reg   <= has_event;
            ev_row_reg     <= has_event ? sel : '0;
            ev_col_reg     <= has_event ? head.column : '0;
            ev_pressed_reg <= has_event && head.sample[sel];
            last_reg       <= is_last;
            done_reg       <= head.pass_done;
            any_reg        <= head.any_down;
            next_col_reg   <= head.next_column;
        end
    end

    assign event_valid   = ev_valid_reg;
    assign event_row     = ev_row_reg;
    assign event_column  = ev_col_reg;
    assign event_pressed = ev_pressed_reg;
    assign last_of_item  = last_reg;
    assign pass_done     = done_reg;
    assign any_key_down  = any_reg;
    assign next_column   = next_col_reg;

endmodule

// ===== hw/rtl/demux_direct_key_matrix_scan_top.sv =====
// Key matrix scan engine for a demultiplexed column bank followed by
// directly driven columns.
// Drive the column shown on next_column, let the rows settle, then push
// the row vector on row_bits; a transfer happens when push is high and
// full is low. Results come out like a queue: while empty is low the
// oldest result is on the result ports, and pop takes it.
// Each item gives one result per changed key, lowest row first, or a
// single result with event_valid low; last_of_item marks its final one.
// The configuration channel takes a write whenever cfg_valid is high
// (cfg_ready always high); index 0-2 writes restart the pass at column 0.
// Write configuration only while no results are pending.
// An accepted item passes the read stage and the queue before its first
// result is loaded into the result register. The front takes one item
// per cycle while full is low; the serializer, which sets the sustained
// rate, emits one result per cycle while pop keeps up.
// Reset releases all keys, starts the pass at column 0 and loads the
// register defaults of 4 demux bits, 8 direct columns and 8 rows.
// If the receiver stalls, up to four classified items wait in the
// internal queue, then full rises until results are taken.
module demux_direct_key_matrix_scan_top
    import dkms_pkg::*;
#(
    parameter int MAX_DEMUX_BITS     = MAX_DEMUX_BITS_DEF,
    parameter int MAX_DIRECT_COLUMNS = MAX_DIRECT_COLUMNS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [ROW_W-1:0]       row_bits,
    output logic                   empty,
    input  logic                   pop,
    output logic                   event_valid,
    output logic [ROW_IDX_W-1:0]   event_row,
    output logic [COL_W-1:0]       event_column,
    output logic                   event_pressed,
    output logic                   last_of_item,
    output logic                   pass_done,
    output logic                   any_key_down,
    output logic [COL_W-1:0]       next_column,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic              q_push;
    dkms_item_t        q_wr_item;
    logic              q_pop;
    dkms_item_t        q_head;
    logic              q_empty;
    logic [QCNT_W-1:0] q_count;

    // Column sequencer, key state and change classification.
    dkms_front #(
        .MAX_DEMUX_BITS     (MAX_DEMUX_BITS),
        .MAX_DIRECT_COLUMNS (MAX_DIRECT_COLUMNS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .row_bits  (row_bits),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_count   (q_count),
        .q_push    (q_push),
        .q_item    (q_wr_item)
    );

    // Classified items waiting for the event serializer.
    dkms_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (q_wr_item),
        .rd_en   (q_pop),
        .rd_item (q_head),
        .q_empty (q_empty),
        .count   (q_count)
    );

    // Event serializer and result register.
    dkms_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .event_valid   (event_valid),
        .event_row     (event_row),
        .event_column  (event_column),
        .event_pressed (event_pressed),
        .last_of_item  (last_of_item),
        .pass_done     (pass_done),
        .any_key_down  (any_key_down),
        .next_column   (next_column)
    );

endmodule
